FILE: rtl/hcls_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants of the rgb565 hsl color classifier
// no dependencies

package hcls_pkg;

  localparam int PIX_W        = 16;
  localparam int CH_W         = 8;
  localparam int SUM_W        = CH_W + 1;
  localparam int HSL_W        = 8;
  localparam int NUM_W        = 16;
  localparam int DEN_W        = SUM_W;
  localparam int QUO_W        = HSL_W;
  localparam int DIV_BITS     = 2;
  localparam int DIV_STAGES   = QUO_W / DIV_BITS;
  localparam int FRONT_STAGES = 2;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_W        = 16;

  localparam logic [HSL_W-1:0] HSL_MAX    = 8'd240;
  localparam logic [HSL_W-1:0] L_HALF     = 8'd120;
  localparam logic [HSL_W-1:0] HUE_STEP   = 8'd40;
  localparam logic [HSL_W-1:0] HUE_BASE_G = 8'd80;
  localparam logic [HSL_W-1:0] HUE_BASE_B = 8'd160;
  localparam logic [SUM_W-1:0] SUM_MAX    = 9'd510;

  // lightness = sum * 120 / 255 = (sum * 8) / 17, reciprocal is ceil(2^17 / 17)
  localparam int               L_SHIFT    = 17;
  localparam logic [12:0]      L_RECIP    = 13'd7711;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef enum logic [1:0] {
    LABEL_NONE   = 2'd0,
    LABEL_RED    = 2'd1,
    LABEL_YELLOW = 2'd2
  } label_t;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
  } bounds_t;

  typedef struct packed {
    bounds_t hue;
    bounds_t sat;
    bounds_t light;
  } window_t;

  typedef struct packed {
    logic             rej;
    sector_t          sector;
    logic             neg;
    logic [HSL_W-1:0] light;
  } side_t;

endpackage

FILE: rtl/hcls_front.sv
`timescale 1ns / 1ps
// front end: byte swap, rgb expansion, min/max, lightness and divider operands
// two register stages, uses hcls_pkg

module hcls_front
  import hcls_pkg::*;
(
  input  logic                        clk,
  input  logic [FRONT_STAGES-1:0]     en,
  input  logic                        swap,
  input  logic [PIX_W-1:0]            pixel,
  output side_t                       side,
  output logic [NUM_W-1:0]            hue_num,
  output logic [DEN_W-1:0]            hue_den,
  output logic [NUM_W-1:0]            sat_num,
  output logic [DEN_W-1:0]            sat_den
);

  logic [PIX_W-1:0] px;
  logic [CH_W-1:0]  r, g, b;
  logic [CH_W-1:0]  maxv, minv, pos, negv;
  sector_t          sec;

  logic             rej_r;
  sector_t          sec_r;
  logic             neg_r;
  logic [CH_W-1:0]  mag_r;
  logic [CH_W-1:0]  diff_r;
  logic [SUM_W-1:0] sum_r;

  logic [24:0]      l_prod;
  logic [HSL_W-1:0] light;
  logic [DEN_W-1:0] sden;

  function automatic logic [7:0] px_lo(input logic [PIX_W-1:0] p);
    return p[7:0];
  endfunction

  // stage 1: decode and sector
  always_comb begin
    px = swap ? {px_lo(pixel), pixel[PIX_W-1:8]} : pixel;
    r  = {px[15:11], px[15:13]};
    g  = {px[10:5], px[10:9]};
    b  = {px[4:0], px[4:2]};
    if (r >= g && r >= b) begin
      sec  = SEC_RED;
      maxv = r;
      minv = (g < b) ? g : b;
      pos  = g;
      negv = b;
    end else if (g >= b) begin
      sec  = SEC_GREEN;
      maxv = g;
      minv = (r < b) ? r : b;
      pos  = b;
      negv = r;
    end else begin
      sec  = SEC_BLUE;
      maxv = b;
      minv = (r < g) ? r : g;
      pos  = r;
      negv = g;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rej_r  <= (b >= r) && (b >= g);
      sec_r  <= sec;
      neg_r  <= pos < negv;
      mag_r  <= (pos < negv) ? (negv - pos) : (pos - negv);
      diff_r <= maxv - minv;
      sum_r  <= {1'b0, maxv} + {1'b0, minv};
    end
  end

  // stage 2: lightness, saturation denominator, scaled numerators
  always_comb begin
    l_prod = 25'({sum_r, 3'b000}) * 25'(L_RECIP);
    light  = l_prod[L_SHIFT +: HSL_W];
    sden   = (light <= L_HALF) ? sum_r : (SUM_MAX - sum_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side.rej    <= rej_r;
      side.sector <= sec_r;
      side.neg    <= neg_r;
      side.light  <= light;
      hue_num     <= NUM_W'(mag_r) * NUM_W'(HUE_STEP);
      hue_den     <= DEN_W'(diff_r);
      sat_num     <= NUM_W'(diff_r) * NUM_W'(HSL_MAX);
      sat_den     <= sden;
    end
  end

endmodule

FILE: rtl/hcls_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, DIV_BITS quotient bits per stage
// quotient assumed below 2^QUO_W, uses hcls_pkg

module hcls_div
  import hcls_pkg::*;
(
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  output logic [QUO_W-1:0]      quo
);

  localparam int WIDE_W = NUM_W + QUO_W;

  logic [NUM_W-1:0] rem_r   [DIV_STAGES];
  logic [DEN_W-1:0] den_r   [DIV_STAGES];
  logic [QUO_W-1:0] quo_r   [DIV_STAGES];
  logic [NUM_W-1:0] rem_in  [DIV_STAGES];
  logic [DEN_W-1:0] den_in  [DIV_STAGES];
  logic [QUO_W-1:0] quo_in  [DIV_STAGES];
  logic [NUM_W-1:0] rem_nxt [DIV_STAGES];
  logic [QUO_W-1:0] quo_nxt [DIV_STAGES];

  always_comb begin
    rem_in[0] = num;
    den_in[0] = den;
    quo_in[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_in[k] = rem_r[k-1];
      den_in[k] = den_r[k-1];
      quo_in[k] = quo_r[k-1];
    end
  end

  always_comb begin
    logic [NUM_W-1:0]  rem_cur;
    logic [QUO_W-1:0]  quo_cur;
    logic [WIDE_W-1:0] shifted;
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_cur = rem_in[k];
      quo_cur = quo_in[k];
      for (int j = 0; j < DIV_BITS; j++) begin
        shifted = WIDE_W'(den_in[k]) << (QUO_W - 1 - k * DIV_BITS - j);
        if (WIDE_W'(rem_cur) >= shifted) begin
          rem_cur = rem_cur - shifted[NUM_W-1:0];
          quo_cur = {quo_cur[QUO_W-2:0], 1'b1};
        end else begin
          quo_cur = {quo_cur[QUO_W-2:0], 1'b0};
        end
      end
      rem_nxt[k] = rem_cur;
      quo_nxt[k] = quo_cur;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_in[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

FILE: rtl/hcls_class.sv
`timescale 1ns / 1ps
// hue assembly and window tests, registered label and reject flag
// uses hcls_pkg

module hcls_class
  import hcls_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  side_t            side,
  input  logic [QUO_W-1:0] hue_quo,
  input  logic [QUO_W-1:0] sat_quo,
  input  window_t          red_win,
  input  window_t          yel_win,
  output logic [1:0]       label,
  output logic             fast_rejected
);

  logic [HSL_W-1:0] hue;
  label_t           label_nxt;

  function automatic logic in_window(input logic [HSL_W-1:0] v, input bounds_t bnd,
                                     input logic may_wrap);
    if (bnd.hi >= bnd.lo) begin
      return (v >= bnd.lo) && (v <= bnd.hi);
    end
    return may_wrap && ((v >= bnd.lo) || (v <= bnd.hi));
  endfunction

  function automatic logic win_match(input logic [HSL_W-1:0] h, input logic [HSL_W-1:0] s,
                                     input logic [HSL_W-1:0] l, input window_t w);
    return in_window(h, w.hue, 1'b1) && in_window(s, w.sat, 1'b0) &&
           in_window(l, w.light, 1'b0);
  endfunction

  always_comb begin
    case (side.sector)
      // negative hue in the red sector wraps, a zero quotient stays zero
      SEC_RED: begin
        hue = (side.neg && hue_quo != '0) ? (HSL_MAX - hue_quo) : hue_quo;
      end
      SEC_GREEN: begin
        hue = side.neg ? (HUE_BASE_G - hue_quo) : (HUE_BASE_G + hue_quo);
      end
      SEC_BLUE: begin
        hue = side.neg ? (HUE_BASE_B - hue_quo) : (HUE_BASE_B + hue_quo);
      end
      default: begin
        hue = '0;
      end
    endcase

    if (side.rej) begin
      label_nxt = LABEL_NONE;
    end else if (win_match(hue, sat_quo, side.light, red_win)) begin
      label_nxt = LABEL_RED;
    end else if (win_match(hue, sat_quo, side.light, yel_win)) begin
      label_nxt = LABEL_YELLOW;
    end else begin
      label_nxt = LABEL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      label         <= label_nxt;
      fast_rejected <= side.rej;
    end
  end

endmodule

FILE: rtl/rgb565_hsl_color_classifier_top.sv
`timescale 1ns / 1ps
// top level of the rgb565 hsl color classifier: config registers, pipeline control
// instantiates hcls_front, hcls_div (hue and saturation) and hcls_class, uses hcls_pkg

// Classifies one RGB565 pixel per clock as none, red or yellow, while out_stall is
// low. The pipeline is seven register stages deep: two front stages (decode,
// min/max, lightness), four divider stages that resolve two quotient bits each for
// the hue and saturation divisions, and one stage for the window tests and the
// output register. out_stall holds only the stages that are full behind it, so
// bubbles are squeezed out before in_stall rises. Configuration writes are always
// accepted and should be made while no pixel is in flight.

module rgb565_hsl_color_classifier_top
  import hcls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_label,
  output logic                 out_fast_rejected,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [CFG_IDX_W-1:0] CFG_SWAP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_HUE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_SAT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_LIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YEL_HUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YEL_SAT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_YEL_LIGHT = 3'd6;

  localparam window_t RED_WIN_RST = '{hue: 16'h0FE6, sat: 16'hF014, light: 16'hF041};
  localparam window_t YEL_WIN_RST = '{hue: 16'h2A12, sat: 16'hF050, light: 16'hF046};

  logic                  swap_r;
  window_t               red_win_r;
  window_t               yel_win_r;

  logic [PIPE_DEPTH-1:0] v_r, v_nxt, en, v_src;
  logic [PIPE_DEPTH:0]   rdy;

  side_t                 front_side;
  logic [NUM_W-1:0]      hue_num, sat_num;
  logic [DEN_W-1:0]      hue_den, sat_den;
  logic [QUO_W-1:0]      hue_quo, sat_quo;
  side_t                 side_r [DIV_STAGES];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r    <= 1'b0;
      red_win_r <= RED_WIN_RST;
      yel_win_r <= YEL_WIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SWAP:      swap_r          <= cfg_data[0];
        CFG_RED_HUE:   red_win_r.hue   <= cfg_data;
        CFG_RED_SAT:   red_win_r.sat   <= cfg_data;
        CFG_RED_LIGHT: red_win_r.light <= cfg_data;
        CFG_YEL_HUE:   yel_win_r.hue   <= cfg_data;
        CFG_YEL_SAT:   yel_win_r.sat   <= cfg_data;
        CFG_YEL_LIGHT: yel_win_r.light <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stage valids and load enables, a stage loads when empty or moving on
  always_comb begin
    rdy[PIPE_DEPTH] = !out_stall;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    en    = rdy[PIPE_DEPTH-1:0];
    v_src = {v_r[PIPE_DEPTH-2:0], in_valid};
    v_nxt = (en & v_src) | (~en & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[PIPE_DEPTH-1];

  hcls_front u_front (
    .clk     (clk),
    .en      (en[FRONT_STAGES-1:0]),
    .swap    (swap_r),
    .pixel   (in_pixel),
    .side    (front_side),
    .hue_num (hue_num),
    .hue_den (hue_den),
    .sat_num (sat_num),
    .sat_den (sat_den)
  );

  hcls_div u_hue_div (
    .clk (clk),
    .en  (en[FRONT_STAGES +: DIV_STAGES]),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo)
  );

  hcls_div u_sat_div (
    .clk (clk),
    .en  (en[FRONT_STAGES +: DIV_STAGES]),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo)
  );

  // sideband travels alongside the divider stages
  always_ff @(posedge clk) begin
    if (en[FRONT_STAGES]) begin
      side_r[0] <= front_side;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[FRONT_STAGES + k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  hcls_class u_class (
    .clk           (clk),
    .en            (en[PIPE_DEPTH-1]),
    .side          (side_r[DIV_STAGES-1]),
    .hue_quo       (hue_quo),
    .sat_quo       (sat_quo),
    .red_win       (red_win_r),
    .yel_win       (yel_win_r),
    .label         (out_label),
    .fast_rejected (out_fast_rejected)
  );

  a_rej_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fast_rejected |-> out_label == LABEL_NONE)
    else $error("fast rejected pixel carries a color label");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output side is free");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && out_stall |-> in_stall)
    else $error("input taken while pipeline is full and stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> v_r == '0)
    else $error("pipeline not empty after reset");

endmodule
